>>> sv/direct_mapped_writeback_cache_defines.svh
// Assertion macros used by the cache controller module.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define DMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dmc_pkg.sv
// Shared types and codes for the direct-mapped write-back cache.
// No dependencies.
package dmc_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;

  localparam logic [2:0] K_READ    = 3'd0;
  localparam logic [2:0] K_WRITE   = 3'd1;
  localparam logic [2:0] K_WB      = 3'd2;
  localparam logic [2:0] K_FILLREQ = 3'd3;
  localparam logic [2:0] K_ERR     = 3'd4;

  // Result address select
  localparam logic [1:0] ASEL_ZERO = 2'd0;
  localparam logic [1:0] ASEL_WB   = 2'd1;
  localparam logic [1:0] ASEL_FILL = 2'd2;

  typedef struct packed {
    logic       cap_in;
    logic       drd_in;
    logic       drd_wb;
    logic       drd_held;
    logic       wb_clr;
    logic       wb_inc;
    logic       fill_wr;
    logic       fill_done;
    logic       line_inval;
    logic       store;
    logic       out_load;
    logic [2:0] out_kind;
    logic       out_hit;
    logic       out_last;
    logic       out_dsel;
    logic [1:0] out_asel;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic dirty;
    logic wb_last;
    logic fill_last;
    logic held_write;
    logic out_free;
  } sts_t;

endpackage

>>> sv/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmc_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/dmc_ctrl.sv
// Controller state machine of the cache: lookup, writeback, fill, completion.
// Depends on dmc_pkg and direct_mapped_writeback_cache_defines.svh.
`include "direct_mapped_writeback_cache_defines.svh"
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_WB_RD  = 3'd2;
  localparam logic [2:0] S_WB_OUT = 3'd3;
  localparam logic [2:0] S_FREQ   = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_CMP_RD = 3'd6;
  localparam logic [2:0] S_CMP    = 3'd7;

  logic [2:0] state, state_next;
  logic       hit_r, hit_r_next;
  logic       acc;

  assign in_ready = (state == S_IDLE || state == S_WAIT) && sts.out_free;
  assign acc      = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    hit_r_next = hit_r;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (opcode == OP_READ || opcode == OP_WRITE) begin
            cmd.cap_in = 1'b1;
            cmd.drd_in = 1'b1;
            state_next = S_LOOK;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_kind = K_ERR;
            cmd.out_last = 1'b1;
          end
        end
      end
      S_LOOK: begin
        if (sts.hit) begin
          hit_r_next = 1'b1;
          state_next = S_CMP;
        end else if (sts.dirty) begin
          cmd.wb_clr = 1'b1;
          state_next = S_WB_RD;
        end else begin
          state_next = S_FREQ;
        end
      end
      S_WB_RD: begin
        cmd.drd_wb = 1'b1;
        state_next = S_WB_OUT;
      end
      S_WB_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = K_WB;
          cmd.out_asel = ASEL_WB;
          cmd.out_dsel = 1'b1;
          cmd.wb_inc   = 1'b1;
          state_next   = sts.wb_last ? S_FREQ : S_WB_RD;
        end
      end
      S_FREQ: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = K_FILLREQ;
          cmd.out_asel   = ASEL_FILL;
          cmd.out_last   = 1'b1;
          cmd.line_inval = 1'b1;
          hit_r_next     = 1'b0;
          state_next     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (acc) begin
          if (opcode == OP_FILL) begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) begin
              cmd.fill_done = 1'b1;
              state_next    = S_CMP_RD;
            end
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_kind = K_ERR;
            cmd.out_last = 1'b1;
          end
        end
      end
      S_CMP_RD: begin
        cmd.drd_held = 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_hit  = hit_r;
          cmd.out_last = 1'b1;
          if (sts.held_write) begin
            cmd.store    = 1'b1;
            cmd.out_kind = K_WRITE;
          end else begin
            cmd.out_kind = K_READ;
            cmd.out_dsel = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hit_r <= 1'b0;
    end else begin
      state <= state_next;
      hit_r <= hit_r_next;
    end
  end

  `DMC_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free, "result loaded over a waiting result")
  `DMC_ASSERT_NXT(a_fill_end, acc && state == S_WAIT && opcode == OP_FILL && sts.fill_last, state == S_CMP_RD, "last fill word did not start completion")
  `DMC_ASSERT_NXT(a_inval_wait, cmd.line_inval, state == S_WAIT, "fill request did not enter fill wait")

endmodule

>>> sv/dmc_dp.sv
// Datapath of the cache: held access, tag and line RAMs, line state bits, result register.
// Depends on dmc_pkg and dmc_ram.
module dmc_dp
  import dmc_pkg::*;
#(
  parameter int SET_INDEX_BITS = 6,
  parameter int LINE_BYTES     = 64,
  parameter int ADDR_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] address,
  input  logic [63:0] data_word,
  input  logic        hold_write,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] mem_address,
  output logic [63:0] data_word_res,
  output logic        hit,
  output logic        last
);

  localparam int OB     = $clog2(LINE_BYTES);
  localparam int LW     = LINE_BYTES / 8;
  localparam int WI_W   = (LW > 1) ? $clog2(LW) : 1;
  localparam int SW     = SET_INDEX_BITS;
  localparam int NSETS  = 1 << SW;
  localparam int AEFF   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int TAG_W  = AEFF - OB - SW;
  localparam int DA_W   = SW + WI_W;
  localparam logic [WI_W-1:0] WI_MAX = WI_W'(LW - 1);

  logic              hwrite;
  logic [31:0]       haddr;
  logic [63:0]       hdata;
  logic [WI_W-1:0]   wbcnt, fillcnt;
  logic [NSETS-1:0]  valid, dirty;

  logic [SW-1:0]     in_set, hset;
  logic [WI_W-1:0]   in_wi, hwi;
  logic [TAG_W-1:0]  htag, tag_rd;
  logic [63:0]       line_rd;
  logic              d_re, d_we;
  logic [DA_W-1:0]   d_raddr, d_waddr;
  logic [63:0]       d_wdata;
  logic [63:0]       wb_base;

  // Split addresses into set, word and tag
  assign in_set = SW'(address >> OB);
  assign in_wi  = WI_W'((address >> 3) & 32'(LW - 1));
  assign hset   = SW'(haddr >> OB);
  assign hwi    = WI_W'((haddr >> 3) & 32'(LW - 1));
  assign htag   = TAG_W'(haddr >> (OB + SW));

  // Hold the access that is in flight
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      hwrite <= hold_write;
      haddr  <= address;
      hdata  <= data_word;
    end
  end

  // Counters and line state bits
  always_ff @(posedge clk) begin
    if (rst) begin
      wbcnt   <= '0;
      fillcnt <= '0;
      valid   <= '0;
      dirty   <= '0;
    end else begin
      if (cmd.wb_clr) begin
        wbcnt <= '0;
      end else if (cmd.wb_inc) begin
        wbcnt <= wbcnt + WI_W'(1);
      end
      if (cmd.fill_done) begin
        fillcnt <= '0;
      end else if (cmd.fill_wr) begin
        fillcnt <= fillcnt + WI_W'(1);
      end
      if (cmd.line_inval) begin
        valid[hset] <= 1'b0;
        dirty[hset] <= 1'b0;
      end
      if (cmd.fill_done) begin
        valid[hset] <= 1'b1;
        dirty[hset] <= 1'b0;
      end
      if (cmd.store) begin
        dirty[hset] <= 1'b1;
      end
    end
  end

  // Tag store
  dmc_ram #(.W(TAG_W), .DEPTH(NSETS)) u_tags (
    .clk   (clk),
    .we    (cmd.fill_done),
    .waddr (hset),
    .wdata (htag),
    .re    (cmd.drd_in),
    .raddr (in_set),
    .rdata (tag_rd)
  );

  // Line data store ports
  always_comb begin
    d_re    = cmd.drd_in | cmd.drd_wb | cmd.drd_held;
    d_raddr = {hset, hwi};
    if (cmd.drd_in) begin
      d_raddr = {in_set, in_wi};
    end else if (cmd.drd_wb) begin
      d_raddr = {hset, wbcnt};
    end
    d_we    = cmd.fill_wr | cmd.store;
    d_waddr = cmd.fill_wr ? {hset, fillcnt} : {hset, hwi};
    d_wdata = cmd.fill_wr ? data_word : hdata;
  end

  dmc_ram #(.W(64), .DEPTH(1 << DA_W)) u_lines (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (line_rd)
  );

  // Status back to the controller
  assign sts.hit        = valid[hset] && (tag_rd == htag);
  assign sts.dirty      = dirty[hset];
  assign sts.wb_last    = (wbcnt == WI_MAX);
  assign sts.fill_last  = (fillcnt == WI_MAX);
  assign sts.held_write = hwrite;
  assign sts.out_free   = !out_valid || out_ready;

  // Rebuild victim address from stored tag
  assign wb_base = (64'(tag_rd) << (OB + SW)) | (64'(hset) << OB) | (64'(wbcnt) << 3);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind          <= cmd.out_kind;
      hit           <= cmd.out_hit;
      last          <= cmd.out_last;
      data_word_res <= cmd.out_dsel ? line_rd : 64'd0;
      case (cmd.out_asel)
        ASEL_WB:   mem_address <= wb_base[31:0];
        ASEL_FILL: mem_address <= haddr & ~32'(LINE_BYTES - 1);
        default:   mem_address <= 32'd0;
      endcase
    end
  end

endmodule

>>> sv/direct_mapped_writeback_cache.sv
// Direct-mapped write-back, write-allocate cache of 64-bit dwords.
// Channels: input beats (opcode, address, data_word) on in_valid/in_ready;
// result beats (kind, mem_address, data_word_res, hit, last) on
// out_valid/out_ready. Opcode 0 reads, 1 writes, 2 delivers a fill dword.
// On a hit, the tag and line RAM reads register on the accepting edge, the
// lookup state compares tags and the completion state loads the result
// register. One item at a time is in work. A miss on a dirty line first
// emits LINE_BYTES/8 writeback beats, each a line RAM read then a result
// load, then a fill request. The block then takes LINE_BYTES/8 fill beats,
// one per cycle while the result register is free, and completes the held
// access by a line read and a result load. A read or write while fill words
// are due, a fill word when none is due, or opcode 3 gives one error beat.
// Reset clears all line state to invalid at once; no clearing pass is needed.
// When the receiver stalls, the pending result holds in the output register
// and the block stops taking input beats until it is free.
// Depends on dmc_pkg, dmc_ctrl, dmc_dp and dmc_ram.
module direct_mapped_writeback_cache
  import dmc_pkg::*;
#(
  parameter int SET_INDEX_BITS = 6,
  parameter int LINE_BYTES     = 64,
  parameter int ADDR_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] address,
  input  logic [63:0] data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] mem_address,
  output logic [63:0] data_word_res,
  output logic        hit,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;
  logic hold_write;

  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dmc_dp #(
    .SET_INDEX_BITS (SET_INDEX_BITS),
    .LINE_BYTES     (LINE_BYTES),
    .ADDR_BITS      (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .address       (address),
    .data_word     (data_word),
    .hold_write    (hold_write),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .mem_address   (mem_address),
    .data_word_res (data_word_res),
    .hit           (hit),
    .last          (last)
  );

  // Held access is a write when the accepted opcode says so
  assign hold_write = (opcode == OP_WRITE);

endmodule

>>> tb/tb_direct_mapped_writeback_cache.sv
// Self-checking testbench for the direct-mapped write-back cache.
// Drives access and fill beats, predicts every result beat in a scoreboard.
// Depends on dmc_pkg and direct_mapped_writeback_cache.
module tb_direct_mapped_writeback_cache;
  import dmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 64;
  localparam int LWORDS = 8;
  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] ST_INV = 2'd0;
  localparam logic [1:0] ST_CLEAN = 2'd1;
  localparam logic [1:0] ST_DIRTY = 2'd2;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [63:0] data;
    logic        hit;
    logic        last;
  } beat_t;

  // Cache model and queue of expected result beats
  class cache_scoreboard;
    logic [19:0] tags[NSETS];
    logic [1:0]  status[NSETS];
    logic [63:0] lines[NSETS*LWORDS];
    logic [1:0]  held_op;
    logic [31:0] held_addr;
    logic [63:0] held_data;
    int          fill_cnt;
    bit          waiting;
    beat_t       pending[$];
    int          errors;

    function new();
      foreach (tags[i]) begin
        tags[i] = '0;
        status[i] = ST_INV;
      end
      foreach (lines[i]) lines[i] = '0;
      waiting = 0;
      fill_cnt = 0;
      errors = 0;
    endfunction

    function void push(logic [2:0] k, logic [31:0] a, logic [63:0] d, logic h,
                       logic l);
      beat_t b;
      b.kind = k; b.addr = a; b.data = d; b.hit = h; b.last = l;
      pending.push_back(b);
    endfunction

    function void finish_access(logic [1:0] op, logic [31:0] a, logic [63:0] d,
                                logic h);
      int s;
      s = int'(a[11:6]);
      if (op == OP_READ) push(K_READ, '0, lines[s*LWORDS + int'(a[5:3])], h, 1'b1);
      else begin
        lines[s*LWORDS + int'(a[5:3])] = d;
        status[s] = ST_DIRTY;
        push(K_WRITE, '0, '0, h, 1'b1);
      end
    endfunction

    function void note_input(logic [1:0] op, logic [31:0] a, logic [63:0] d);
      int s;
      int hs;
      s = int'(a[11:6]);
      hs = int'(held_addr[11:6]);
      if (waiting) begin
        if (op != OP_FILL) begin
          push(K_ERR, '0, '0, 1'b0, 1'b1);
          return;
        end
        lines[hs*LWORDS + fill_cnt] = d;
        fill_cnt++;
        if (fill_cnt < LWORDS) return;
        tags[hs] = held_addr[31:12];
        status[hs] = ST_CLEAN;
        waiting = 0;
        fill_cnt = 0;
        finish_access(held_op, held_addr, held_data, 1'b0);
        return;
      end
      if (op > OP_WRITE) begin
        push(K_ERR, '0, '0, 1'b0, 1'b1);
        return;
      end
      if (status[s] != ST_INV && tags[s] == a[31:12]) begin
        finish_access(op, a, d, 1'b1);
        return;
      end
      if (status[s] == ST_DIRTY)
        for (int i = 0; i < LWORDS; i++)
          push(K_WB, {tags[s], s[5:0], i[2:0], 3'b000}, lines[s*LWORDS + i],
               1'b0, 1'b0);
      status[s] = ST_INV;
      held_op = op; held_addr = a; held_data = d;
      fill_cnt = 0;
      waiting = 1;
      push(K_FILLREQ, {a[31:6], 6'b0}, '0, 1'b0, 1'b1);
    endfunction

    function void check_result(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d addr=%h data=%h", $time,
                 got.kind, got.addr, got.data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.addr != want.addr) begin
        $display("%0t: mem_address expected %h actual %h", $time, want.addr, got.addr);
        errors++;
      end
      if (got.data != want.data) begin
        $display("%0t: data_word_res expected %h actual %h", $time, want.data,
                 got.data);
        errors++;
      end
      if (got.hit != want.hit) begin
        $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [31:0] address = '0;
  logic [63:0] data_word = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  kind;
  logic [31:0] mem_address;
  logic [63:0] data_word_res;
  logic        hit;
  logic        last;

  cache_scoreboard sb;
  int send_idle_pct = 14;
  int recv_idle_pct = 84;
  int quiet_cycles = 0;
  logic [31:0] tag_pool[4];

  direct_mapped_writeback_cache dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Randomly stall the receiver; check each accepted result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result({kind, mem_address, data_word_res, hit, last});
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (!rst) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one beat, with a random idle gap before it; valid drops only when idling
  task automatic send_beat(logic [1:0] op, logic [31:0] a, logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    address <= a;
    data_word <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, a, d);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Access plus, on a miss, its full set of fill words
  task automatic access(logic [1:0] op, logic [31:0] a, logic [63:0] d);
    send_beat(op, a, d);
    while (sb.waiting) send_beat(OP_FILL, $urandom(), rand64());
  endtask

  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(3) != 0) begin
      // few sets and tags so hits and evictions are common
      a[31:12] = tag_pool[$urandom_range(3)][31:12];
      a[11:6] = 6'($urandom_range(3));
    end
    return a;
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 85) access(2'($urandom_range(1)), pick_addr(), rand64());
      else if (r < 90) send_beat(OP_FILL, $urandom(), rand64());
      else if (r < 94) send_beat(OP_UNDEF, $urandom(), rand64());
      else begin
        // broken sequence: access while fill words are due
        send_beat(2'($urandom_range(1)), pick_addr(), rand64());
        if (sb.waiting) send_beat(2'($urandom_range(1)), $urandom(), rand64());
        while (sb.waiting) send_beat(OP_FILL, $urandom(), rand64());
      end
    end
  endtask

  // Drop valid and wait for every expected result
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: protocol errors, extremes, hits, dirty eviction
    send_beat(OP_FILL, 32'h0, 64'h0);
    send_beat(OP_UNDEF, 32'hFFFF_FFFF, '1);
    access(OP_READ, 32'h0, 64'h0);
    access(OP_WRITE, 32'h0000_0007, '1);
    access(OP_READ, 32'h0000_0038, '0);
    access(OP_WRITE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    access(OP_READ, 32'hFFFF_FFF8, '0);
    access(OP_WRITE, 32'h0000_1000, 64'h0123_4567_89AB_CDEF);
    access(OP_READ, 32'h0000_0000, '0);
    send_beat(OP_WRITE, 32'h0000_2040, 64'hA5A5);
    send_beat(OP_READ, 32'h0, '0);
    send_beat(OP_UNDEF, 32'h0, '0);
    while (sb.waiting) send_beat(OP_FILL, 32'hFFFF_FFFF, rand64());
    access(OP_READ, 32'h0000_2040, '0);

    random_phase(6);
    drain();
    send_idle_pct = 84;
    recv_idle_pct = 14;
    random_phase(6);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(6);
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
